>>> src/mpce_pkg.sv
package mpce_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;
    localparam int MUL_BITS       = 17;
    localparam int PROD_BITS      = 2 * MUL_BITS;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_X_STRIDE     = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_Y_STRIDE     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PIXEL_FORMAT = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FG_COLOR     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BG_COLOR     = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OPAQUE_MODE  = 3'd6;

    localparam logic OP_START   = 1'b0;
    localparam logic OP_PATTERN = 1'b1;

    localparam logic [1:0] FMT_8BPP  = 2'd0;
    localparam logic [1:0] FMT_16BPP = 2'd1;
    localparam logic [1:0] FMT_24BPP = 2'd2;
    localparam logic [1:0] FMT_32BPP = 2'd3;

    localparam logic [7:0] PAT_TOP_BIT = 8'h80;

    typedef struct packed {
        logic [31:0]        base_address;
        logic signed [5:0]  x_stride;
        logic signed [16:0] y_stride;
        logic [1:0]         pixel_format;
        logic [31:0]        fg_color;
        logic [31:0]        bg_color;
        logic               opaque_mode;
    } cfg_t;

    function automatic logic [31:0] colour_mask(input logic [1:0] fmt);
        logic [31:0] m;
        unique case (fmt)
            FMT_8BPP:  m = 32'h0000_00FF;
            FMT_16BPP: m = 32'h0000_FFFF;
            FMT_24BPP: m = 32'h00FF_FFFF;
            FMT_32BPP: m = 32'hFFFF_FFFF;
            default:   m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

>>> src/mpce_cfg.sv
module mpce_cfg
    import mpce_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASE_ADDRESS: cfg_next.base_address = cfg_data;
                REG_X_STRIDE:     cfg_next.x_stride     = cfg_data[5:0];
                REG_Y_STRIDE:     cfg_next.y_stride     = cfg_data[16:0];
                REG_PIXEL_FORMAT: cfg_next.pixel_format = cfg_data[1:0];
                REG_FG_COLOR:     cfg_next.fg_color     = cfg_data;
                REG_BG_COLOR:     cfg_next.bg_color     = cfg_data;
                REG_OPAQUE_MODE:  cfg_next.opaque_mode  = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_address <= '0;
            cfg_reg.x_stride     <= 6'sd1;
            cfg_reg.y_stride     <= '0;
            cfg_reg.pixel_format <= FMT_8BPP;
            cfg_reg.fg_color     <= '0;
            cfg_reg.bg_color     <= '0;
            cfg_reg.opaque_mode  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/mpce_alu.sv
module mpce_alu
    import mpce_pkg::*;
#(
    parameter int ADDR_BITS = 32
)
(
    input  logic                       use_mul,
    input  logic [ADDR_BITS-1:0]       x,
    input  logic [ADDR_BITS-1:0]       z,
    input  logic signed [MUL_BITS-1:0] a,
    input  logic signed [MUL_BITS-1:0] b,
    output logic [ADDR_BITS-1:0]       sum
);

    logic signed [PROD_BITS-1:0] prod;
    logic [ADDR_BITS-1:0]        term;

    // The product is sign-extended or cut to the address width; the sum wraps.
    always_comb
    begin
        prod = a * b;
        term = use_mul ? ADDR_BITS'(prod) : z;
        sum  = x + term;
    end

endmodule

>>> src/mono_pattern_color_expand_blit.sv
// Colour-expansion blitter: a start beat (op 0) sets up a rectangle; once it
// is accepted, it makes three passes through the one shared multiply-add unit
// (start address in two passes, row skip in one). A pattern beat (op 1) is
// accepted and then gives one pixel per cycle while the output slot is free,
// up to eight, plus a row-skip step when the byte ends a row, since the row
// skip goes through the same adder as the column step; the output register
// lets the last pixel wait while the next beat is taken. A stalled output
// holds the pixel sequence. Pattern beats while no rectangle is open are dropped.
module mono_pattern_color_expand_blit
    import mpce_pkg::*;
#(
    parameter int ADDR_BITS  = 32,
    parameter int COORD_BITS = 12
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic                      op,
    input  logic [COORD_BITS-1:0]     pos_x,
    input  logic [COORD_BITS-1:0]     pos_y,
    input  logic [7:0]                rect_width,
    input  logic [7:0]                rect_height,
    input  logic [7:0]                pattern,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [31:0]               write_address,
    output logic [31:0]               write_data,
    output logic                      write_enable,
    output logic [2:0]                byte_count,
    output logic                      last_of_byte,
    output logic                      rect_done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL0 = 3'd1;
    localparam logic [2:0] S_MUL1 = 3'd2;
    localparam logic [2:0] S_MUL2 = 3'd3;
    localparam logic [2:0] S_PIX  = 3'd4;
    localparam logic [2:0] S_SKIP = 3'd5;

    cfg_t cfg;

    mpce_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic [2:0]            state_reg, state_next;
    logic                  active_reg, active_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [ADDR_BITS-1:0]  skip_reg, skip_next;
    logic [8:0]            cols_reg, cols_next;
    logic [8:0]            rows_reg, rows_next;
    logic [8:0]            width_reg, width_next;
    logic [COORD_BITS-1:0] px_reg, px_next;
    logic [COORD_BITS-1:0] py_reg, py_next;
    logic [7:0]            pat_reg, pat_next;
    logic [2:0]            bit_reg, bit_next;

    logic                  out_valid_reg, out_valid_next;
    logic [31:0]           out_addr_reg, out_addr_next;
    logic [31:0]           out_data_reg, out_data_next;
    logic                  out_en_reg, out_en_next;
    logic [2:0]            out_count_reg, out_count_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_done_reg, out_done_next;

    logic                       alu_use_mul;
    logic [ADDR_BITS-1:0]       alu_x;
    logic [ADDR_BITS-1:0]       alu_z;
    logic signed [MUL_BITS-1:0] alu_a;
    logic signed [MUL_BITS-1:0] alu_b;
    logic [ADDR_BITS-1:0]       alu_sum;

    mpce_alu #(
        .ADDR_BITS (ADDR_BITS)
    ) u_alu (
        .use_mul (alu_use_mul),
        .x       (alu_x),
        .z       (alu_z),
        .a       (alu_a),
        .b       (alu_b),
        .sum     (alu_sum)
    );

    logic                       in_fire;
    logic                       slot_free;
    logic                       pix_fire;
    logic                       bit_set;
    logic                       pix_en;
    logic                       row_end;
    logic                       last_rect_row;
    logic signed [MUL_BITS-1:0] xs_ext;
    logic signed [MUL_BITS-1:0] ys_ext;

    assign in_ready      = (state_reg == S_IDLE);
    assign in_fire       = in_valid && in_ready;
    assign slot_free     = !out_valid_reg || out_ready;
    assign pix_fire      = (state_reg == S_PIX) && slot_free;
    assign bit_set       = (pat_reg & PAT_TOP_BIT) != 8'd0;
    assign pix_en        = bit_set || cfg.opaque_mode;
    assign row_end       = (cols_reg == 9'd1);
    assign last_rect_row = (rows_reg == 9'd1);
    assign xs_ext        = MUL_BITS'(cfg.x_stride);
    assign ys_ext        = MUL_BITS'(cfg.y_stride);

    // Operand selection for the shared multiply-add unit.
    always_comb
    begin
        alu_use_mul = 1'b1;
        alu_x       = addr_reg;
        alu_z       = ADDR_BITS'(xs_ext);
        alu_a       = $signed(MUL_BITS'(px_reg));
        alu_b       = xs_ext;
        unique case (state_reg)
            S_MUL0:
            begin
                alu_x = ADDR_BITS'(cfg.base_address);
            end
            S_MUL1:
            begin
                alu_a = $signed(MUL_BITS'(py_reg));
                alu_b = ys_ext;
            end
            S_MUL2:
            begin
                // Row skip is y_stride minus width times x_stride.
                alu_x = ADDR_BITS'(ys_ext);
                alu_a = $signed(MUL_BITS'(width_reg));
                alu_b = -xs_ext;
            end
            S_PIX:
            begin
                alu_use_mul = 1'b0;
            end
            S_SKIP:
            begin
                alu_use_mul = 1'b0;
                alu_z       = skip_reg;
            end
            default:
            begin
                alu_use_mul = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        addr_next      = addr_reg;
        skip_next      = skip_reg;
        cols_next      = cols_reg;
        rows_next      = rows_reg;
        width_next     = width_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pat_next       = pat_reg;
        bit_next       = bit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_addr_next  = out_addr_reg;
        out_data_next  = out_data_reg;
        out_en_next    = out_en_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_done_next  = out_done_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (op == OP_START)
                    begin
                        px_next     = pos_x;
                        py_next     = pos_y;
                        width_next  = (rect_width == 8'd0) ? 9'd256 : {1'b0, rect_width};
                        cols_next   = (rect_width == 8'd0) ? 9'd256 : {1'b0, rect_width};
                        rows_next   = (rect_height == 8'd0) ? 9'd256 : {1'b0, rect_height};
                        active_next = 1'b1;
                        state_next  = S_MUL0;
                    end
                    else if (active_reg)
                    begin
                        pat_next   = pattern;
                        bit_next   = 3'd0;
                        state_next = S_PIX;
                    end
                end
            end
            S_MUL0:
            begin
                addr_next  = alu_sum;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                addr_next  = alu_sum;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                skip_next  = alu_sum;
                state_next = S_IDLE;
            end
            S_PIX:
            begin
                if (pix_fire)
                begin
                    out_valid_next = 1'b1;
                    out_addr_next  = 32'(addr_reg);
                    out_data_next  = pix_en
                        ? ((bit_set ? cfg.fg_color : cfg.bg_color)
                           & colour_mask(cfg.pixel_format))
                        : 32'd0;
                    out_en_next    = pix_en;
                    out_count_next = {1'b0, cfg.pixel_format} + 3'd1;
                    out_last_next  = row_end || (bit_reg == 3'd7);
                    out_done_next  = row_end && last_rect_row;

                    addr_next = alu_sum;
                    pat_next  = pat_reg << 1;
                    bit_next  = bit_reg + 3'd1;
                    if (row_end)
                    begin
                        // Remaining bits of the byte are dropped at a row end.
                        cols_next  = width_reg;
                        rows_next  = rows_reg - 9'd1;
                        state_next = S_SKIP;
                        if (last_rect_row)
                        begin
                            active_next = 1'b0;
                            cols_next   = 9'd0;
                        end
                    end
                    else
                    begin
                        cols_next  = cols_reg - 9'd1;
                        state_next = (bit_reg == 3'd7) ? S_IDLE : S_PIX;
                    end
                end
            end
            S_SKIP:
            begin
                addr_next  = alu_sum;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            addr_reg      <= '0;
            skip_reg      <= '0;
            cols_reg      <= '0;
            rows_reg      <= '0;
            width_reg     <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            addr_reg      <= addr_next;
            skip_reg      <= skip_next;
            cols_reg      <= cols_next;
            rows_reg      <= rows_next;
            width_reg     <= width_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg        <= px_next;
        py_reg        <= py_next;
        pat_reg       <= pat_next;
        out_addr_reg  <= out_addr_next;
        out_data_reg  <= out_data_next;
        out_en_reg    <= out_en_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    assign out_valid     = out_valid_reg;
    assign write_address = out_addr_reg;
    assign write_data    = out_data_reg;
    assign write_enable  = out_en_reg;
    assign byte_count    = out_count_reg;
    assign last_of_byte  = out_last_reg;
    assign rect_done     = out_done_reg;

endmodule

>>> dv/mono_pattern_color_expand_blit_test.sv
`timescale 1ns / 1ps

module mono_pattern_color_expand_blit_test;
    import mpce_pkg::*;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] data;
        logic        enable;
        logic [2:0]  count;
        logic        last;
        logic        done;
    } pixel_t;

    // Tracks the rectangle being expanded and holds the pixel writes still owed by the block.
    class pixel_expander;
        logic [31:0]        base;
        logic signed [5:0]  x_step;
        logic signed [16:0] y_step;
        logic [1:0]         fmt;
        logic [31:0]        fg;
        logic [31:0]        bg;
        logic               opaque;

        logic               active;
        logic [31:0]        pixel_addr;
        logic [8:0]         cols_left;
        logic [8:0]         rows_left;
        logic [8:0]         row_width;
        logic [31:0]        row_skip;

        pixel_t             pending_pixels[$];
        int                 errors;

        function new();
            base = '0;
            x_step = 6'sd1;
            y_step = '0;
            fmt = FMT_8BPP;
            fg = '0;
            bg = '0;
            opaque = 1'b0;
            active = 1'b0;
            pixel_addr = '0;
            cols_left = '0;
            rows_left = '0;
            row_width = '0;
            row_skip = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] v);
            case (idx)
                REG_BASE_ADDRESS: base = v;
                REG_X_STRIDE:     x_step = v[5:0];
                REG_Y_STRIDE:     y_step = v[16:0];
                REG_PIXEL_FORMAT: fmt = v[1:0];
                REG_FG_COLOR:     fg = v;
                REG_BG_COLOR:     bg = v;
                REG_OPAQUE_MODE:  opaque = v[0];
                default: ;
            endcase
        endfunction

        function void take_beat(logic op_i, logic [11:0] px, logic [11:0] py,
                                logic [7:0] w, logic [7:0] h, logic [7:0] pat);
            logic [31:0] xs;
            logic [31:0] ys;
            logic [31:0] cmask;
            logic [8:0]  wb;
            logic [8:0]  hb;
            logic [7:0]  bitm;
            logic        set;
            logic        en;
            logic        row_end;
            pixel_t      p;
            xs = {{26{x_step[5]}}, x_step};
            ys = {{15{y_step[16]}}, y_step};
            if (op_i == OP_START) begin
                wb = (w == 8'd0) ? 9'd256 : {1'b0, w};
                hb = (h == 8'd0) ? 9'd256 : {1'b0, h};
                pixel_addr = base + {20'd0, px} * xs + {20'd0, py} * ys;
                row_width = wb;
                cols_left = wb;
                rows_left = hb;
                row_skip = ys - {23'd0, wb} * xs;
                active = 1'b1;
            end else if (active) begin
                case (fmt)
                    FMT_8BPP:  cmask = 32'h0000_00FF;
                    FMT_16BPP: cmask = 32'h0000_FFFF;
                    FMT_24BPP: cmask = 32'h00FF_FFFF;
                    default:   cmask = 32'hFFFF_FFFF;
                endcase
                bitm = PAT_TOP_BIT;
                p = '0;
                while (bitm != 8'd0 && !p.last) begin
                    set = (pat & bitm) != 8'd0;
                    en = set || opaque;
                    p.address = pixel_addr;
                    p.data = en ? ((set ? fg : bg) & cmask) : 32'd0;
                    p.enable = en;
                    p.count = {1'b0, fmt} + 3'd1;
                    p.done = 1'b0;
                    pixel_addr = pixel_addr + xs;
                    if (cols_left > 0) cols_left = cols_left - 9'd1;
                    row_end = (cols_left == 9'd0);
                    if (row_end) begin
                        pixel_addr = pixel_addr + row_skip;
                        cols_left = row_width;
                        if (rows_left > 0) rows_left = rows_left - 9'd1;
                        if (rows_left == 9'd0) begin
                            p.done = 1'b1;
                            active = 1'b0;
                            cols_left = '0;
                        end
                    end
                    bitm = bitm >> 1;
                    p.last = row_end || (bitm == 8'd0);
                    if (!p.last) p.done = 1'b0;
                    pending_pixels.push_back(p);
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] e, logic [31:0] g);
            if (e !== g) begin
                $display("%0t: %s expected %h, got %h", $time, name, e, g);
                errors++;
            end
        endfunction

        function void match_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel write, expected none, got address %h data %h",
                         $time, got.address, got.data);
                errors++;
            end else begin
                want = pending_pixels.pop_front();
                compare_field("write_address", want.address, got.address);
                compare_field("write_data", want.data, got.data);
                compare_field("write_enable", 32'(want.enable), 32'(got.enable));
                compare_field("byte_count", 32'(want.count), 32'(got.count));
                compare_field("last_of_byte", 32'(want.last), 32'(got.last));
                compare_field("rect_done", 32'(want.done), 32'(got.done));
            end
        endfunction
    endclass

    localparam int STALL_LIMIT = 2000;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      op;
    logic [11:0]               pos_x;
    logic [11:0]               pos_y;
    logic [7:0]                rect_width;
    logic [7:0]                rect_height;
    logic [7:0]                pattern;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [31:0]               write_address;
    logic [31:0]               write_data;
    logic                      write_enable;
    logic [2:0]                byte_count;
    logic                      last_of_byte;
    logic                      rect_done;

    pixel_expander model;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    int items_sent;

    mono_pattern_color_expand_blit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .rect_width    (rect_width),
        .rect_height   (rect_height),
        .pattern       (pattern),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .write_address (write_address),
        .write_data    (write_data),
        .write_enable  (write_enable),
        .byte_count    (byte_count),
        .last_of_byte  (last_of_byte),
        .rect_done     (rect_done)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Both channels are sampled at the edge, before any of this step's updates land.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1) begin
            if (in_valid && in_ready)
                model.take_beat(op, pos_x, pos_y, rect_width, rect_height, pattern);
            if (out_valid && out_ready)
                model.match_pixel('{write_address, write_data, write_enable, byte_count,
                                    last_of_byte, rect_done});
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Valid is only lowered when an idle gap is taken, so back-to-back beats keep it high.
    task automatic send_beat(logic op_i, logic [11:0] px, logic [11:0] py,
                             logic [7:0] w, logic [7:0] h, logic [7:0] pat);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= op_i;
        pos_x <= px;
        pos_y <= py;
        rect_width <= w;
        rect_height <= h;
        pattern <= pat;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_start(logic [11:0] px, logic [11:0] py, logic [7:0] w, logic [7:0] h);
        send_beat(OP_START, px, py, w, h, 8'($urandom));
    endtask

    task automatic send_pattern(logic [7:0] pat);
        send_beat(OP_PATTERN, 12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom), pat);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        model.set_reg(idx, v);
    endtask

    task automatic write_config(logic [31:0] base, logic signed [5:0] xs,
                                logic signed [16:0] ys, logic [1:0] fmt,
                                logic [31:0] fg, logic [31:0] bg, logic opq);
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_X_STRIDE, {{26{xs[5]}}, xs});
        write_reg(REG_Y_STRIDE, {{15{ys[16]}}, ys});
        write_reg(REG_PIXEL_FORMAT, {30'd0, fmt});
        write_reg(REG_FG_COLOR, fg);
        write_reg(REG_BG_COLOR, bg);
        write_reg(REG_OPAQUE_MODE, {31'd0, opq});
        cfg_we <= 1'b0;
    endtask

    // Closes any open rectangle, then lets every owed pixel come out and the block settle.
    task automatic drain();
        if (model.active) begin
            send_start(12'd0, 12'd0, 8'd1, 8'd1);
            send_pattern(8'($urandom));
        end
        in_valid <= 1'b0;
        while (model.pending_pixels.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic random_config();
        logic [31:0] base;
        logic [31:0] fg;
        logic [31:0] bg;
        int          xs;
        int          ys;
        base = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0)
                                           : $urandom;
        xs = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 16 : -16)
                                         : int'($urandom_range(0, 32)) - 16;
        ys = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 65535 : -65536)
                                         : int'($urandom_range(0, 131071)) - 65536;
        fg = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
        bg = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        write_config(base, 6'(xs), 17'(ys), 2'($urandom_range(0, 3)), fg, bg,
                     1'($urandom_range(0, 1)));
    endtask

    // Mostly complete rectangles of modest size; some are cut short and a few are huge.
    task automatic run_rect();
        logic [7:0] w;
        logic [7:0] h;
        int         wb;
        int         hb;
        int         need;
        int         nbytes;
        if ($urandom_range(0, 99) < 10) begin
            w = 8'($urandom);
            h = 8'($urandom);
        end else begin
            w = 8'($urandom_range(1, 24));
            h = 8'($urandom_range(1, 4));
        end
        wb = (w == 8'd0) ? 256 : int'(w);
        hb = (h == 8'd0) ? 256 : int'(h);
        need = hb * ((wb + 7) / 8);
        if (need > 40)
            nbytes = $urandom_range(1, 8);
        else if ($urandom_range(0, 99) < 10)
            nbytes = $urandom_range(1, need);
        else
            nbytes = need;
        send_start(12'($urandom), 12'($urandom), w, h);
        repeat (nbytes) send_pattern(8'($urandom));
        items_sent += 1 + nbytes;
        if (nbytes == need && $urandom_range(0, 99) < 15)
            repeat ($urandom_range(1, 2)) send_pattern(8'($urandom));
    endtask

    initial
    begin
        model = new();
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        op <= OP_START;
        pos_x <= '0;
        pos_y <= '0;
        rect_width <= '0;
        rect_height <= '0;
        pattern <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values, a pattern with no rectangle open, and a row ending mid-byte.
        send_pattern(8'hFF);
        send_start(12'd5, 12'd7, 8'd3, 8'd2);
        send_pattern(8'hA5);
        send_pattern(8'h5A);
        drain();

        write_config(32'hFFFF_FFF0, -6'sd16, 17'sd65535, FMT_32BPP,
                     32'hFFFF_FFFF, 32'h1234_5678, 1'b1);
        send_start(12'hFFF, 12'hFFF, 8'd9, 8'd1);
        send_pattern(8'h00);
        send_pattern(8'hFF);
        // Zero width and height mean 256; the rectangle is abandoned by a new start.
        send_start(12'd0, 12'd0, 8'd0, 8'd0);
        send_pattern(8'hFF);
        send_pattern(8'h00);
        send_start(12'd1, 12'd2, 8'd8, 8'd2);
        send_pattern(8'h81);
        send_pattern(8'h7E);
        drain();

        write_config(32'd0, 6'sd16, -17'sd65536, FMT_8BPP, 32'h0000_00A5, 32'h0000_005A, 1'b0);
        send_start(12'hFFF, 12'd0, 8'd255, 8'd255);
        send_pattern(8'hF0);
        send_start(12'd3, 12'd4, 8'd1, 8'd3);
        send_pattern(8'h80);
        send_pattern(8'h00);
        send_pattern(8'hFF);
        send_pattern(8'h01);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 18; recv_idle_pct = 69; end
                1: begin send_idle_pct = 69; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int seg = 0; seg < 3; seg++) begin
                random_config();
                items_sent = 0;
                while (items_sent < 18) run_rect();
                drain();
            end
        end

        if (model.errors == 0 && model.pending_pixels.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/mpce_pkg.sv
src/mpce_cfg.sv
src/mpce_alu.sv
src/mono_pattern_color_expand_blit.sv
dv/mono_pattern_color_expand_blit_test.sv
